// ===== design/sct_pkg.sv =====
// Shared constants, types and helpers for the counting semaphore table.
package sct_pkg;

    localparam int NUM_SEM  = 32;
    localparam int WQ_DEPTH = 16;

    localparam int IDX_W   = (NUM_SEM > 1) ? $clog2(NUM_SEM) : 1;
    localparam int SCAN_W  = $clog2(NUM_SEM + 1);
    localparam int PTR_W   = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;
    localparam int LEN_W   = $clog2(WQ_DEPTH + 1);
    localparam int WADDR_W = (NUM_SEM * WQ_DEPTH > 1) ? $clog2(NUM_SEM * WQ_DEPTH) : 1;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // request codes
    localparam logic [1:0] REQ_CREATE = 2'd0;
    localparam logic [1:0] REQ_WAIT   = 2'd1;
    localparam logic [1:0] REQ_POST   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_WAKE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0]      key;
        logic [15:0]      count;
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [LEN_W-1:0] len;
    } t_ent_rec;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_ent_rec         rec;
    } t_tbl_wr;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(WQ_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + PTR_W'(1);
        end
        return res;
    endfunction

    function automatic logic [WADDR_W-1:0] wq_addr(input logic [IDX_W-1:0] idx,
                                                   input logic [PTR_W-1:0] ptr);
        return WADDR_W'(idx) * WADDR_W'(WQ_DEPTH) + WADDR_W'(ptr);
    endfunction

endpackage

// ===== design/sct_entry_table.sv =====
// Semaphore entry table: in-use flags plus record memory (key, count, queue pointers).
module sct_entry_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [sct_pkg::IDX_W-1:0] i_raddr,
    output sct_pkg::t_ent_rec        o_rec,
    output logic [sct_pkg::NUM_SEM-1:0] o_in_use,
    input  sct_pkg::t_tbl_wr         i_wr
);
    import sct_pkg::*;

    t_ent_rec               mem [NUM_SEM];
    t_ent_rec               r_rec;
    logic [NUM_SEM-1:0]     r_in_use;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.rec;
        end
        r_rec <= mem[i_raddr];
    end

    // any record write marks the entry as claimed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
        end else if (i_wr.en) begin
            r_in_use[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rec    = r_rec;
    assign o_in_use = r_in_use;

endmodule

// ===== design/sct_waiter_ram.sv =====
// Wait queue storage: one slot per semaphore and queue position.
module sct_waiter_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [sct_pkg::WADDR_W-1:0] i_waddr,
    input  logic [5:0]                  i_wdata,
    input  logic [sct_pkg::WADDR_W-1:0] i_raddr,
    output logic [5:0]                  o_rdata
);
    import sct_pkg::*;

    logic [5:0] mem [NUM_SEM * WQ_DEPTH];
    logic [5:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/counting_semaphore_table_unit.sv =====
// Top level: request sequencer for the counting semaphore table.
//
// Input channel (i_valid/o_ready) carries one request: create, wait or post
// on the semaphore named by i_sem_key. Output channel (o_valid/i_ready)
// returns one result per request: status, blocked flag and woken thread.
// One request is in flight at a time; o_ready is high only while idle.
// A single read port on the entry record memory is stepped through the
// table one entry per cycle and its registered output is compared against
// the key (or the in-use flag for create). A create claims the first free
// entry it meets; a wait or post that matches an entry goes on to S_EXEC,
// and a post that wakes a waiter passes through S_WAKE for the wait queue
// RAM read. An unmatched key or a full table scans all 32 entries; an
// undefined request type goes straight to S_DONE. The next request can
// transfer only after the result transfer, once the block is back in idle.
// Reset clears all in-use flags, so the table starts empty; no clearing
// pass is needed. The result is held in registers until transferred; while
// the receiver stalls the block takes no new request.
module counting_semaphore_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_sem_key,
    input  logic [15:0] i_init_value,
    input  logic [5:0]  i_thread_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_blocked,
    output logic        o_woken_valid,
    output logic [5:0]  o_woken_thread
);
    import sct_pkg::*;

    t_state             r_state, n_state;
    logic [1:0]         r_req;
    logic [31:0]        r_key;
    logic [15:0]        r_init;
    logic [5:0]         r_tid;
    logic [SCAN_W-1:0]  r_scan, n_scan;
    logic               r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]   r_ent, n_ent;
    t_ent_rec           r_rec, n_rec;
    logic [1:0]         r_status, n_status;
    logic               r_blocked, n_blocked;
    logic               r_wvalid, n_wvalid;
    logic [5:0]         r_wthread, n_wthread;

    t_ent_rec           tbl_rec;
    logic [NUM_SEM-1:0] tbl_in_use;
    t_tbl_wr            tbl_wr;
    logic               wq_we;
    logic [5:0]         wq_rdata;
    logic               accept;
    logic               cur_used;

    sct_entry_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_raddr  (r_scan[IDX_W-1:0]),
        .o_rec    (tbl_rec),
        .o_in_use (tbl_in_use),
        .i_wr     (tbl_wr)
    );

    sct_waiter_ram u_waiters (
        .i_clk   (i_clk),
        .i_we    (wq_we),
        .i_waddr (wq_addr(r_ent, r_rec.tail)),
        .i_wdata (r_tid),
        .i_raddr (wq_addr(r_ent, r_rec.head)),
        .o_rdata (wq_rdata)
    );

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign accept         = i_valid && o_ready;
    assign o_status       = r_status;
    assign o_blocked      = r_blocked;
    assign o_woken_valid  = r_wvalid;
    assign o_woken_thread = r_wthread;
    assign cur_used       = tbl_in_use[r_cmp_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req_type;
            r_key  <= i_sem_key;
            r_init <= i_init_value;
            r_tid  <= i_thread_id;
        end
        r_scan    <= n_scan;
        r_cmp_idx <= n_cmp_idx;
        r_ent     <= n_ent;
        r_rec     <= n_rec;
        r_status  <= n_status;
        r_blocked <= n_blocked;
        r_wvalid  <= n_wvalid;
        r_wthread <= n_wthread;
    end

    always_comb begin
        n_state   = r_state;
        n_scan    = r_scan;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_ent     = r_ent;
        n_rec     = r_rec;
        n_status  = r_status;
        n_blocked = r_blocked;
        n_wvalid  = r_wvalid;
        n_wthread = r_wthread;
        tbl_wr    = '0;
        wq_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                n_scan    = '0;
                n_cmp_vld = 1'b0;
                if (accept) begin
                    n_status  = ST_MISS;
                    n_blocked = 1'b0;
                    n_wvalid  = 1'b0;
                    n_wthread = '0;
                    if (i_req_type == REQ_CREATE || i_req_type == REQ_WAIT ||
                        i_req_type == REQ_POST) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            S_SCAN: begin
                // issue next table read; its registered data is compared in the following cycle
                if (r_scan < SCAN_W'(NUM_SEM)) begin
                    n_scan    = r_scan + SCAN_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_scan[IDX_W-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (r_cmp_vld) begin
                    if (r_req == REQ_CREATE && !cur_used) begin
                        tbl_wr.en        = 1'b1;
                        tbl_wr.addr      = r_cmp_idx;
                        tbl_wr.rec.key   = r_key;
                        tbl_wr.rec.count = r_init;
                        tbl_wr.rec.head  = '0;
                        tbl_wr.rec.tail  = '0;
                        tbl_wr.rec.len   = '0;
                        n_status         = ST_OK;
                        n_state          = S_DONE;
                    end else if (r_req != REQ_CREATE && cur_used &&
                                 tbl_rec.key == r_key) begin
                        n_ent   = r_cmp_idx;
                        n_rec   = tbl_rec;
                        n_state = S_EXEC;
                    end else if (r_cmp_idx == IDX_W'(NUM_SEM - 1)) begin
                        n_state = S_DONE;
                    end
                end
            end

            S_EXEC: begin
                tbl_wr.addr = r_ent;
                tbl_wr.rec  = r_rec;
                n_status    = ST_OK;
                n_state     = S_DONE;
                if (r_req == REQ_WAIT) begin
                    if (r_rec.count != 16'd0) begin
                        tbl_wr.en        = 1'b1;
                        tbl_wr.rec.count = r_rec.count - 16'd1;
                    end else if (r_rec.len >= LEN_W'(WQ_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        wq_we           = 1'b1;
                        tbl_wr.en       = 1'b1;
                        tbl_wr.rec.tail = next_ptr(r_rec.tail);
                        tbl_wr.rec.len  = r_rec.len + LEN_W'(1);
                        n_blocked       = 1'b1;
                    end
                end else begin
                    if (r_rec.len != '0) begin
                        // waiter RAM read at head is already addressed
                        tbl_wr.en       = 1'b1;
                        tbl_wr.rec.head = next_ptr(r_rec.head);
                        tbl_wr.rec.len  = r_rec.len - LEN_W'(1);
                        n_state         = S_WAKE;
                    end else if (r_rec.count != COUNT_MAX) begin
                        tbl_wr.en        = 1'b1;
                        tbl_wr.rec.count = r_rec.count + 16'd1;
                    end
                end
            end

            S_WAKE: begin
                n_wvalid  = 1'b1;
                n_wthread = wq_rdata;
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the counting semaphore table unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sct_pkg::*;

    localparam logic [1:0] REQ_UNDEF   = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [1:0] status;
        logic       blocked;
        logic       woken_valid;
        logic [5:0] woken_thread;
    } t_sem_result;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [1:0]  i_req_type   = REQ_CREATE;
    logic [31:0] i_sem_key    = '0;
    logic [15:0] i_init_value = '0;
    logic [5:0]  i_thread_id  = '0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_blocked;
    logic        o_woken_valid;
    logic [5:0]  o_woken_thread;

    counting_semaphore_table_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_sem_key      (i_sem_key),
        .i_init_value   (i_init_value),
        .i_thread_id    (i_thread_id),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_blocked      (o_blocked),
        .o_woken_valid  (o_woken_valid),
        .o_woken_thread (o_woken_thread)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the semaphore table
    logic        sem_in_use   [NUM_SEM];
    logic [31:0] sem_key_tab  [NUM_SEM];
    logic [15:0] sem_count    [NUM_SEM];
    logic [5:0]  sleeper_ring [NUM_SEM][WQ_DEPTH];
    int          ring_head    [NUM_SEM];
    int          ring_tail    [NUM_SEM];
    int          ring_len     [NUM_SEM];
    int          entries_used;

    t_sem_result pending_results[$];
    int          errors        = 0;
    int          cycle_count   = 0;
    bit          steady_flow   = 1'b0;
    int          hold_request  = 0;
    int          stall_left    = 0;

    task automatic reset_table_model();
        for (int i = 0; i < NUM_SEM; i++) begin
            sem_in_use[i] = 1'b0;
            ring_head[i]  = 0;
            ring_tail[i]  = 0;
            ring_len[i]   = 0;
        end
        entries_used = 0;
    endtask

    // lowest in-use entry holding this key, -1 if none
    function automatic int lookup_entry(input logic [31:0] key);
        for (int i = 0; i < NUM_SEM; i++) begin
            if (sem_in_use[i] && sem_key_tab[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_sem_result predict_request(input logic [1:0]  req,
                                                    input logic [31:0] key,
                                                    input logic [15:0] init,
                                                    input logic [5:0]  tid);
        t_sem_result res;
        int          e;
        res        = '0;
        res.status = ST_MISS;
        case (req)
            REQ_CREATE: begin
                for (e = 0; e < NUM_SEM; e++) begin
                    if (!sem_in_use[e]) begin
                        sem_in_use[e]  = 1'b1;
                        sem_key_tab[e] = key;
                        sem_count[e]   = init;
                        ring_head[e]   = 0;
                        ring_tail[e]   = 0;
                        ring_len[e]    = 0;
                        entries_used++;
                        res.status = ST_OK;
                        break;
                    end
                end
            end
            REQ_WAIT: begin
                e = lookup_entry(key);
                if (e >= 0) begin
                    if (sem_count[e] != 16'd0) begin
                        sem_count[e] = sem_count[e] - 16'd1;
                        res.status   = ST_OK;
                    end else if (ring_len[e] >= WQ_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        sleeper_ring[e][ring_tail[e]] = tid;
                        ring_tail[e] = (ring_tail[e] + 1) % WQ_DEPTH;
                        ring_len[e]++;
                        res.status  = ST_OK;
                        res.blocked = 1'b1;
                    end
                end
            end
            REQ_POST: begin
                e = lookup_entry(key);
                if (e >= 0) begin
                    res.status = ST_OK;
                    if (ring_len[e] > 0) begin
                        res.woken_valid  = 1'b1;
                        res.woken_thread = sleeper_ring[e][ring_head[e]];
                        ring_head[e] = (ring_head[e] + 1) % WQ_DEPTH;
                        ring_len[e]--;
                    end else if (sem_count[e] != COUNT_MAX) begin
                        sem_count[e] = sem_count[e] + 16'd1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // mostly short pauses, now and then a long one
    function automatic int pick_pause();
        if ($urandom_range(0, 99) < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] pick_init();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 16'($urandom_range(0, 3));
        end else if (r < 80) begin
            return 16'($urandom());
        end else if (r < 90) begin
            return COUNT_MAX;
        end
        return COUNT_MAX - 16'd1;
    endfunction

    // one request transfer; the expected result is queued at acceptance
    task automatic send_request(input logic [1:0]  req,
                                input logic [31:0] key,
                                input logic [15:0] init,
                                input logic [5:0]  tid);
        int gap;
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_sem_key    <= key;
        i_init_value <= init;
        i_thread_id  <= tid;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(predict_request(req, key, init, tid));
        gap = (steady_flow || $urandom_range(0, 99) < 65) ? 0 : pick_pause();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if (!steady_flow && $urandom_range(0, 99) < 25) begin
            i_ready <= 1'b0;
            stall_left = pick_pause() - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_sem_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: status %0d", o_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_blocked !== want.blocked) begin
                    $error("blocked: expected %0d, got %0d", want.blocked, o_blocked);
                    errors++;
                end
                if (o_woken_valid !== want.woken_valid) begin
                    $error("woken_valid: expected %0d, got %0d",
                           want.woken_valid, o_woken_valid);
                    errors++;
                end
                if (o_woken_thread !== want.woken_thread) begin
                    $error("woken_thread: expected %0d, got %0d",
                           want.woken_thread, o_woken_thread);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_basic_ops();
        send_request(REQ_CREATE, 32'h0, 16'd2, 6'd0);
        send_request(REQ_WAIT, 32'h0, 16'd0, 6'd63);
        send_request(REQ_WAIT, 32'h0, 16'hFFFF, 6'd0);
        send_request(REQ_WAIT, 32'h0, 16'd0, 6'd63);   // count is zero: sleeps
        send_request(REQ_WAIT, 32'h0, 16'd0, 6'd21);
        send_request(REQ_POST, 32'h0, 16'd0, 6'd42);
        send_request(REQ_POST, 32'h0, 16'd0, 6'd0);
        send_request(REQ_POST, 32'h0, 16'd0, 6'd0);
    endtask

    task automatic test_count_saturation();
        send_request(REQ_CREATE, 32'hFFFF_FFFF, COUNT_MAX, 6'd63);
        send_request(REQ_POST, 32'hFFFF_FFFF, 16'd0, 6'd63);
        send_request(REQ_WAIT, 32'hFFFF_FFFF, 16'd0, 6'd63);
        send_request(REQ_POST, 32'hFFFF_FFFF, 16'd0, 6'd0);
        send_request(REQ_POST, 32'hFFFF_FFFF, 16'd0, 6'd0);
    endtask

    // same key created twice: the lower entry wins every lookup
    task automatic test_duplicate_key();
        send_request(REQ_CREATE, 32'hA5A5_5A5A, 16'd0, 6'd1);
        send_request(REQ_CREATE, 32'hA5A5_5A5A, 16'd7, 6'd2);
        send_request(REQ_WAIT, 32'hA5A5_5A5A, 16'd0, 6'd42);
        send_request(REQ_POST, 32'hA5A5_5A5A, 16'd0, 6'd3);
    endtask

    task automatic test_misses();
        send_request(REQ_WAIT, 32'h1234_5678, 16'd0, 6'd5);
        send_request(REQ_POST, 32'h5A5A_A5A5, 16'd0, 6'd5);
        send_request(REQ_UNDEF, 32'h0, 16'd0, 6'd0);
        send_request(REQ_UNDEF, 32'hFFFF_FFFF, 16'hFFFF, 6'd63);
    endtask

    // fill one wait queue past its depth, then drain it through the wrap
    task automatic test_wait_queue_full();
        logic [31:0] key;
        key = $urandom();
        send_request(REQ_CREATE, key, 16'd0, 6'($urandom()));
        repeat (WQ_DEPTH + 2) send_request(REQ_WAIT, key, 16'($urandom()), 6'($urandom()));
        repeat (WQ_DEPTH + 2) send_request(REQ_POST, key, 16'($urandom()), 6'($urandom()));
    endtask

    task automatic test_random_traffic(input int n_items);
        int          sent;
        int          pick;
        int          burst_len;
        int          wait_pct;
        logic [31:0] key;
        logic [1:0]  req;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 4 || entries_used == 0) begin
                send_request(REQ_CREATE, $urandom(), pick_init(), 6'($urandom()));
                sent++;
            end else if (pick < 14) begin
                req = 2'($urandom_range(1, 3));
                send_request(req, $urandom(), 16'($urandom()), 6'($urandom()));
                sent++;
            end else begin
                // run of waits and posts on one live semaphore
                key       = sem_key_tab[$urandom_range(0, entries_used - 1)];
                burst_len = $urandom_range(1, 24);
                case ($urandom_range(0, 2))
                    0:       wait_pct = 20;
                    1:       wait_pct = 50;
                    default: wait_pct = 85;
                endcase
                repeat (burst_len) begin
                    req = ($urandom_range(0, 99) < wait_pct) ? REQ_WAIT : REQ_POST;
                    send_request(req, key, 16'($urandom()), 6'($urandom()));
                end
                sent += burst_len;
            end
        end
    endtask

    task automatic test_steady_stream();
        steady_flow = 1'b1;
        test_random_traffic(100);
        steady_flow = 1'b0;
    endtask

    // result side holds off while requests keep coming
    task automatic test_backpressure();
        hold_request = 400;
        steady_flow  = 1'b1;
        test_random_traffic(12);
        steady_flow  = 1'b0;
    endtask

    task automatic test_table_full();
        while (entries_used < NUM_SEM) begin
            send_request(REQ_CREATE, $urandom(), pick_init(), 6'($urandom()));
        end
        repeat (3) send_request(REQ_CREATE, $urandom(), 16'($urandom()), 6'($urandom()));
    endtask

    initial begin
        reset_table_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_count_saturation();
        test_duplicate_key();
        test_misses();
        drain_results();
        test_wait_queue_full();
        drain_results();
        test_random_traffic(600);
        test_steady_stream();
        test_backpressure();
        drain_results();
        test_table_full();
        test_random_traffic(600);
        drain_results();

        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
